### sv/strip_cluster_threshold_qualifier_top_assert.svh
// assertion macros for the strip cluster qualifier
`ifndef STRIP_CLUSTER_THRESHOLD_QUALIFIER_TOP_ASSERT_SVH
`define STRIP_CLUSTER_THRESHOLD_QUALIFIER_TOP_ASSERT_SVH

// clocked check, disabled while reset is asserted
`define SCTQ_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("sctq check failed");

// clocked check that also holds across reset
`define SCTQ_ASSERT_RST(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("sctq reset check failed");

`endif

### sv/sctq_pkg.sv
// types and codes shared by the strip cluster qualifier
package sctq_pkg;

    // register indexes on the configuration port
    localparam logic [2:0] REG_CLUSTER_THR   = 3'd0;
    localparam logic [2:0] REG_SEED_THR      = 3'd1;
    localparam logic [2:0] REG_NEIGHBOUR_THR = 3'd2;
    localparam logic [2:0] REG_NOISE_MODE    = 3'd3;
    localparam logic [2:0] REG_STON_BKG_MAX  = 3'd4;
    localparam logic [2:0] REG_STON_SIG_MIN  = 3'd5;

    // noise modes
    localparam logic [1:0] NOISE_RMS  = 2'd0;
    localparam logic [1:0] NOISE_QUAD = 2'd1;

    // verdict codes
    localparam logic [2:0] VERDICT_FAIL_SEED    = 3'd0;
    localparam logic [2:0] VERDICT_FAIL_CLUSTER = 3'd1;
    localparam logic [2:0] VERDICT_BACKGROUND   = 3'd2;
    localparam logic [2:0] VERDICT_SIGNAL       = 3'd3;
    localparam logic [2:0] VERDICT_OVERLAP      = 3'd4;

    // sequencer states
    typedef enum logic [14:0] {
        ST_IDLE  = 15'b000000000000001,
        ST_INC   = 15'b000000000000010,
        ST_SQ    = 15'b000000000000100,
        ST_WGT   = 15'b000000000001000,
        ST_SEED  = 15'b000000000010000,
        ST_THC   = 15'b000000000100000,
        ST_M4    = 15'b000000001000000,
        ST_SS    = 15'b000000010000000,
        ST_M2    = 15'b000000100000000,
        ST_NDIV  = 15'b000001000000000,
        ST_SQRT  = 15'b000010000000000,
        ST_SLD   = 15'b000100000000000,
        ST_SDIV  = 15'b001000000000000,
        ST_PLD   = 15'b010000000000000,
        ST_OUT   = 15'b100000000000000
    } t_state;

endpackage

### sv/strip_cluster_threshold_qualifier_top.sv
// Strip cluster qualifier: per-strip accumulation and end-of-cluster cuts.
// An excluded strip passes IDLE and INC; an included one also SQ and WGT (shared multiplier).
// After the last strip the sequencer works out the cuts, noise norm, signal-to-noise and
// position, the divisions on the one-bit-per-cycle divider and square root unit.
// The result waits in an output register; the next cluster starts once it loads.
// Reset is synchronous, active low: registers to defaults, cluster state cleared.
module strip_cluster_threshold_qualifier_top
    import sctq_pkg::*;
#(
    parameter int MAX_STRIPS = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [11:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_strip_charge,
    input  logic [11:0] i_strip_noise,
    input  logic [9:0]  i_first_strip,
    input  logic        i_last_of_cluster,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_verdict,
    output logic [14:0] o_signal_sum,
    output logic [11:0] o_noise_norm,
    output logic [15:0] o_signal_to_noise,
    output logic [7:0]  o_width,
    output logic [14:0] o_position
);

    localparam int W_OFF = $clog2(MAX_STRIPS + 1);
    localparam int W_SIG = 8 + W_OFF;
    localparam int W_NSS = 24 + W_OFF;
    localparam int W_WS  = 8 + 2 * W_OFF;
    localparam int W_MA  = (2 * W_SIG > W_NSS) ? 2 * W_SIG : W_NSS;
    localparam int W_MB  = (W_SIG > 16) ? W_SIG : 16;
    localparam int W_PR  = W_MA + W_MB;
    localparam int W_CMP = W_PR + 16;
    localparam int W_D1  = (W_NSS > W_SIG + 8) ? W_NSS : W_SIG + 8;
    localparam int W_D0  = (W_D1 > W_WS + 4) ? W_D1 : W_WS + 4;
    localparam int W_DD  = W_D0 + (W_D0 % 2);
    localparam int W_DV  = (W_SIG > 12) ? W_SIG : 12;
    localparam int W_IT  = $clog2(W_DD + 1);
    localparam int W_RT  = W_DD / 2;

    // configuration registers
    logic [7:0]  r_thc, r_ths, r_thn;
    logic [1:0]  r_mode;
    logic [11:0] r_bkg, r_sig_min;

    // cluster state
    logic [W_SIG-1:0] r_sig;
    logic [W_NSS-1:0] r_nss;
    logic [W_OFF-1:0] r_cnt, r_off;
    logic [W_WS-1:0]  r_ws;
    logic [7:0]       r_pc;
    logic [11:0]      r_pn;
    logic [9:0]       r_org;

    // current strip
    logic [7:0]  r_c;
    logic [11:0] r_n;
    logic        r_last;

    // end-of-cluster work registers
    t_state           r_state, n_state;
    logic             r_seed_fail;
    logic [W_MA-1:0]  r_mtmp;
    logic [W_PR-1:0]  r_lhs, r_rhs;
    logic [11:0]      r_nn;
    logic [15:0]      r_ston;
    logic [14:0]      r_pos;

    // shared divider and square root unit
    logic [W_DD-1:0]  r_quo;
    logic [W_DV-1:0]  r_rem, r_dvs;
    logic [W_RT+1:0]  r_sq_rem;
    logic [W_RT-1:0]  r_sq_root;
    logic [W_IT-1:0]  r_it;

    // output register
    logic        r_ovalid;
    logic [2:0]  r_verdict;
    logic [14:0] r_osig, r_opos;
    logic [11:0] r_onn;
    logic [15:0] r_oston;
    logic [7:0]  r_owidth;

    // shared multiplier operand select
    logic [W_MA-1:0] t_ma;
    logic [W_MB-1:0] t_mb;
    logic [W_PR-1:0] t_prod;

    always_comb begin
        t_ma = '0;
        t_mb = '0;
        case (r_state)
            ST_INC: begin
                t_ma = W_MA'(r_n);
                t_mb = W_MB'(r_thn);
            end
            ST_SQ: begin
                t_ma = W_MA'(r_n);
                t_mb = W_MB'(r_n);
            end
            ST_WGT: begin
                t_ma = W_MA'(r_off);
                t_mb = W_MB'(r_c);
            end
            ST_SEED: begin
                t_ma = W_MA'(r_pn);
                t_mb = W_MB'(r_ths);
            end
            ST_THC: begin
                t_ma = W_MA'(r_thc);
                t_mb = W_MB'(r_thc);
            end
            ST_M4: begin
                t_ma = W_MA'(r_nss);
                t_mb = W_MB'(r_mtmp[15:0]);
            end
            ST_SS: begin
                t_ma = W_MA'(r_sig);
                t_mb = W_MB'(r_sig);
            end
            ST_M2: begin
                t_ma = r_mtmp;
                t_mb = (r_mode == NOISE_RMS) ? W_MB'(r_cnt) : W_MB'(1);
            end
            default: begin
                t_ma = '0;
                t_mb = '0;
            end
        endcase
        t_prod = W_PR'(t_ma) * W_PR'(t_mb);
    end

    // divider step: shift one dividend bit into the remainder
    logic [W_DV:0]   t_dshift, t_ddiff;
    logic            t_dge;
    // square root step: two operand bits per cycle
    logic [W_RT+1:0] t_srem, t_strial;
    logic            t_sge;

    always_comb begin
        t_dshift = {r_rem, r_quo[W_DD-1]};
        t_ddiff  = t_dshift - {1'b0, r_dvs};
        t_dge    = t_dshift >= {1'b0, r_dvs};
        t_srem   = {r_sq_rem[W_RT-1:0], r_quo[W_DD-1:W_DD-2]};
        t_strial = {r_sq_root, 2'b01};
        t_sge    = t_srem >= t_strial;
    end

    // verdict from the stored cut results
    logic       t_cfail;
    logic [2:0] t_verdict;

    always_comb begin
        t_cfail = (r_cnt == '0) || (W_CMP'({r_lhs, 16'h0000}) < W_CMP'(r_rhs));
        if (r_seed_fail) begin
            t_verdict = VERDICT_FAIL_SEED;
        end else if (t_cfail) begin
            t_verdict = VERDICT_FAIL_CLUSTER;
        end else if ((r_ston > 16'(r_bkg)) && (r_ston < 16'(r_sig_min))) begin
            t_verdict = VERDICT_OVERLAP;
        end else if (r_ston > 16'(r_bkg)) begin
            t_verdict = VERDICT_SIGNAL;
        end else begin
            t_verdict = VERDICT_BACKGROUND;
        end
    end

    logic t_accept, t_out_free, t_noise_div;

    assign t_accept    = i_in_valid && !o_in_stall;
    assign t_out_free  = !r_ovalid || !i_out_stall;
    assign t_noise_div = (r_mode == NOISE_RMS) || (r_mode == NOISE_QUAD);

    // position division runs inside ST_PLD once loaded
    logic r_pdiv;

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (t_accept) begin
                    if (r_off < W_OFF'(MAX_STRIPS)) begin
                        n_state = ST_INC;
                    end else if (i_last_of_cluster) begin
                        n_state = ST_SEED;
                    end
                end
            end
            ST_INC: begin
                if (W_PR'({r_c, 8'h00}) >= t_prod) begin
                    n_state = ST_SQ;
                end else begin
                    n_state = r_last ? ST_SEED : ST_IDLE;
                end
            end
            ST_SQ:   n_state = ST_WGT;
            ST_WGT:  n_state = r_last ? ST_SEED : ST_IDLE;
            ST_SEED: n_state = ST_THC;
            ST_THC:  n_state = ST_M4;
            ST_M4:   n_state = ST_SS;
            ST_SS:   n_state = ST_M2;
            ST_M2:   n_state = (t_noise_div && r_cnt != '0) ? ST_NDIV : ST_SLD;
            ST_NDIV: n_state = (r_it == '0) ? ST_SQRT : ST_NDIV;
            ST_SQRT: n_state = (r_it == '0) ? ST_SLD : ST_SQRT;
            ST_SLD: begin
                n_state = (r_sig == '0 || r_nn == '0) ? ST_PLD : ST_SDIV;
            end
            ST_SDIV: n_state = (r_it == '0) ? ST_PLD : ST_SDIV;
            ST_PLD: begin
                if (r_sig == '0 || (r_pdiv && r_it == '0)) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_PLD;
                end
            end
            ST_OUT:  n_state = t_out_free ? ST_IDLE : ST_OUT;
            default: n_state = ST_IDLE;
        endcase
    end

    // control and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_thc    <= 8'd80;
            r_ths    <= 8'd48;
            r_thn    <= 8'd32;
            r_mode   <= NOISE_RMS;
            r_bkg    <= 12'd160;
            r_sig_min <= 12'd320;
            r_sig    <= '0;
            r_nss    <= '0;
            r_cnt    <= '0;
            r_off    <= '0;
            r_ws     <= '0;
            r_pc     <= '0;
            r_pn     <= '0;
            r_org    <= '0;
            r_ovalid <= 1'b0;
            r_pdiv   <= 1'b0;
            r_it     <= '0;
        end else begin
            r_state <= n_state;

            // configuration writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_CLUSTER_THR:   r_thc     <= i_cfg_data[7:0];
                    REG_SEED_THR:      r_ths     <= i_cfg_data[7:0];
                    REG_NEIGHBOUR_THR: r_thn     <= i_cfg_data[7:0];
                    REG_NOISE_MODE:    r_mode    <= i_cfg_data[1:0];
                    REG_STON_BKG_MAX:  r_bkg     <= i_cfg_data;
                    REG_STON_SIG_MIN:  r_sig_min <= i_cfg_data;
                    default: ;
                endcase
            end

            // output beat taken downstream; the output state reloads it itself
            if (r_ovalid && !i_out_stall && r_state != ST_OUT) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (t_accept) begin
                        r_c    <= i_strip_charge;
                        r_n    <= i_strip_noise;
                        r_last <= i_last_of_cluster;
                        if (r_off == '0) begin
                            r_org <= i_first_strip;
                        end
                    end
                end
                ST_INC: begin
                    if (r_off == '0 || r_c > r_pc) begin
                        r_pc <= r_c;
                        r_pn <= r_n;
                    end
                    if (!(W_PR'({r_c, 8'h00}) >= t_prod)) begin
                        r_off <= r_off + 1'b1;
                    end
                end
                ST_SQ: begin
                    r_nss <= r_nss + W_NSS'(t_prod);
                    r_sig <= r_sig + W_SIG'(r_c);
                    r_cnt <= r_cnt + 1'b1;
                end
                ST_WGT: begin
                    r_ws  <= r_ws + W_WS'(t_prod);
                    r_off <= r_off + 1'b1;
                end
                ST_SEED: r_seed_fail <= W_PR'({r_pc, 8'h00}) < t_prod;
                ST_THC:  r_mtmp <= W_MA'(t_prod);
                ST_M4:   r_rhs  <= t_prod;
                ST_SS:   r_mtmp <= W_MA'(t_prod);
                ST_M2: begin
                    r_lhs <= t_prod;
                    if (t_noise_div && r_cnt != '0) begin
                        r_quo <= W_DD'(r_nss);
                        r_rem <= '0;
                        r_dvs <= W_DV'(r_cnt);
                        r_it  <= W_IT'(W_DD);
                    end else begin
                        r_nn <= t_noise_div ? 12'd0 : r_pn;
                    end
                end
                ST_NDIV, ST_SDIV: begin
                    if (r_it != '0) begin
                        r_rem <= t_dge ? t_ddiff[W_DV-1:0] : t_dshift[W_DV-1:0];
                        r_quo <= {r_quo[W_DD-2:0], t_dge};
                        r_it  <= r_it - 1'b1;
                    end else if (r_state == ST_NDIV) begin
                        // quotient stays in r_quo as the root operand
                        r_sq_rem  <= '0;
                        r_sq_root <= '0;
                        r_it      <= W_IT'(W_RT);
                    end else begin
                        r_ston <= (r_quo > W_DD'(16'hFFFF)) ? 16'hFFFF : r_quo[15:0];
                    end
                end
                ST_SQRT: begin
                    if (r_it != '0) begin
                        r_sq_rem  <= t_sge ? t_srem - t_strial : t_srem;
                        r_sq_root <= {r_sq_root[W_RT-2:0], t_sge};
                        r_quo     <= {r_quo[W_DD-3:0], 2'b00};
                        r_it      <= r_it - 1'b1;
                    end else begin
                        r_nn <= r_sq_root[11:0];
                    end
                end
                ST_SLD: begin
                    if (r_sig == '0) begin
                        r_ston <= 16'd0;
                    end else if (r_nn == '0) begin
                        r_ston <= 16'hFFFF;
                    end else begin
                        r_quo <= W_DD'({r_sig, 8'h00});
                        r_rem <= '0;
                        r_dvs <= W_DV'(r_nn);
                        r_it  <= W_IT'(W_DD);
                    end
                end
                ST_PLD: begin
                    if (r_sig == '0) begin
                        r_pos <= {r_org, 4'h0} + 15'd0;
                    end else if (!r_pdiv) begin
                        r_quo  <= W_DD'({r_ws, 4'h0});
                        r_rem  <= '0;
                        r_dvs  <= W_DV'(r_sig);
                        r_it   <= W_IT'(W_DD);
                        r_pdiv <= 1'b1;
                    end else if (r_it != '0) begin
                        r_rem <= t_dge ? t_ddiff[W_DV-1:0] : t_dshift[W_DV-1:0];
                        r_quo <= {r_quo[W_DD-2:0], t_dge};
                        r_it  <= r_it - 1'b1;
                    end else begin
                        r_pos   <= 15'(W_DD'({r_org, 4'h0}) + r_quo);
                        r_pdiv  <= 1'b0;
                    end
                end
                ST_OUT: begin
                    if (t_out_free) begin
                        r_ovalid  <= 1'b1;
                        r_verdict <= t_verdict;
                        r_osig    <= 15'(r_sig);
                        r_onn     <= r_nn;
                        r_oston   <= r_ston;
                        r_owidth  <= 8'(r_cnt);
                        r_opos    <= r_pos;
                        r_sig     <= '0;
                        r_nss     <= '0;
                        r_cnt     <= '0;
                        r_off     <= '0;
                        r_ws      <= '0;
                        r_pc      <= '0;
                        r_pn      <= '0;
                        r_org     <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_in_stall        = (r_state != ST_IDLE);
    assign o_out_valid       = r_ovalid;
    assign o_verdict         = r_verdict;
    assign o_signal_sum      = r_osig;
    assign o_noise_norm      = r_onn;
    assign o_signal_to_noise = r_oston;
    assign o_width           = r_owidth;
    assign o_position        = r_opos;

    `include "strip_cluster_threshold_qualifier_top_assert.svh"

    // a result only appears after the output state
    `SCTQ_ASSERT(a_out_from_seq, $rose(o_out_valid) |-> $past(r_state == ST_OUT))
    // strip counters stay in range
    `SCTQ_ASSERT(a_off_range, r_off <= W_OFF'(MAX_STRIPS))
    `SCTQ_ASSERT(a_cnt_le_off, (r_state != ST_WGT) |-> (r_cnt <= r_off))
    // a held result keeps the sequencer waiting
    `SCTQ_ASSERT(a_out_wait,
        (r_state == ST_OUT && r_ovalid && i_out_stall) |=> r_state == ST_OUT)
    // reset empties the output register
    `SCTQ_ASSERT_RST(a_rst_empty, !i_rst_n |=> !o_out_valid)

endmodule
